// ===== design/rth_pkg.sv =====
`timescale 1ns / 1ps
package rth_pkg;
  localparam int CompW = 8;
  localparam int HueW = 15;
  localparam int SatW = 16;
  localparam int SumW = 9;
  localparam int InW = 24;
  localparam int OutW = 40;
  localparam int HueScale = 3840;
  localparam int SatScale = 65535;
  localparam int QuoW = 24;
  localparam int RecipShift = 24;
  localparam int RecipW = 25;
  localparam int RecipDepth = 256;

  typedef logic [RecipW-1:0] recip_t;
endpackage

// ===== design/rgb_to_hsl_converter.sv =====
`timescale 1ns / 1ps
// rgb to hsl, one pixel per cycle unless the output stalls, with a four-stage
// pipeline; the two reciprocal dividers set the depth. s_axis_tdata holds
// red, green, blue; m_axis_tdata holds hue, saturation, lightness_sum. a
// stall on the output freezes the whole pipeline, so nothing is lost.
module rgb_to_hsl_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // hue, saturation, lightness_sum
);
  localparam int QW = rth_pkg::QuoW;

  logic [3:0] vld;
  logic en;
  logic [7:0] r, g, b, mx, mn;
  logic [7:0] d1;
  logic [8:0] sum1;
  logic [7:0] den1;
  logic [10:0] n1;
  logic [8:0] sum_p [4];
  logic [8:0] sumc;
  logic [10:0] nc;
  logic [QW-1:0] hq, sq;

  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[3];
  assign r = s_axis_tdata[7:0];
  assign g = s_axis_tdata[15:8];
  assign b = s_axis_tdata[23:16];

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sumc = {1'b0, mx} + {1'b0, mn};
    if (mx == r) begin
      nc = (g < b) ? 11'({3'd0, g} - {3'd0, b} + 11'd6 * {3'd0, mx - mn})
                   : 11'({3'd0, g} - {3'd0, b});
    end else if (mx == g) begin
      nc = 11'({3'd0, b} - {3'd0, r} + 11'd2 * {3'd0, mx - mn});
    end else begin
      nc = 11'({3'd0, r} - {3'd0, g} + 11'd4 * {3'd0, mx - mn});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= mx - mn;
      sum1 <= sumc;
      den1 <= (sumc <= 9'd255) ? sumc[7:0] : 8'(9'd510 - sumc);
      n1 <= nc;
      sum_p[0] <= sumc;
      sum_p[1] <= sum_p[0];
      sum_p[2] <= sum_p[1];
      sum_p[3] <= sum_p[2];
    end
  end

  rth_div #(.NumW(QW)) u_hue (
    .clk(clk), .en(en),
    .num(QW'(n1) * QW'(rth_pkg::HueScale)),
    .den(d1), .quo(hq)
  );
  rth_div #(.NumW(QW)) u_sat (
    .clk(clk), .en(en),
    .num(QW'(d1) * QW'(rth_pkg::SatScale)),
    .den(den1), .quo(sq)
  );

  logic unused;
  assign unused = ^{sum1, hq[QW-1:15], sq[QW-1:16]};

  assign m_axis_tdata = {sum_p[3], sq[15:0], hq[14:0]};
endmodule

// ===== design/rth_div.sv =====
`timescale 1ns / 1ps
// quotient of numerator by 8-bit divisor; reciprocal multiply, then fix-up
// by one subtract. three register stages, stall by enable
module rth_div #(
  parameter int NumW = rth_pkg::QuoW
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NumW-1:0]  num,
  input  logic [7:0]       den,
  output logic [NumW-1:0]  quo
);
  localparam int ProdW = NumW + rth_pkg::RecipW;

  logic [NumW-1:0] num1;
  logic [7:0] den1;
  logic [rth_pkg::RecipW-1:0] rcp1;
  logic [NumW-1:0] num2;
  logic [7:0] den2;
  logic [NumW-1:0] est2;
  logic [ProdW-1:0] prod;
  logic [NumW+8:0] back;
  logic [NumW-1:0] est_dec;
  logic [NumW-1:0] est_fix;
  logic [rth_pkg::RecipW-1:0] rtab [rth_pkg::RecipDepth];

  // reciprocal table, floor(2^shift / v) + 1
  assign rtab[0] = '0;
  for (genvar i = 1; i < rth_pkg::RecipDepth; i++) begin : g_rtab
    localparam longint Rv = (longint'(1) << rth_pkg::RecipShift) / longint'(i) + 1;
    assign rtab[i] = rth_pkg::recip_t'(Rv);
  end

  assign prod = ProdW'(num1) * ProdW'(rcp1);
  assign est_dec = (est2 == '0) ? est2 : est2 - 1'b1;
  assign back = (NumW + 9)'(est2) * (NumW + 9)'(den2);
  always_comb begin
    if (back > (NumW + 9)'(num2)) begin
      est_fix = est_dec;
    end else begin
      est_fix = est2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= num;
      den1 <= den;
      rcp1 <= rtab[den];
      num2 <= num1;
      den2 <= den1;
      est2 <= prod[rth_pkg::RecipShift+NumW-1:rth_pkg::RecipShift];
      quo  <= est_fix;
    end
  end
endmodule

// ===== design/rth_checker.sv =====
`timescale 1ns / 1ps
module rth_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
  a_hue: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[14:0] < 15'd23040)
    else $error("hue out of range");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_grey: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[30:15] == 16'd0 |-> m_axis_tdata[14:0] == 15'd0)
    else $error("grey pixel with hue");
  logic unused;
  assign unused = s_axis_tvalid;
endmodule

bind rgb_to_hsl_converter rth_checker u_rth_checker (.*);

// ===== verif/rgb_to_hsl_converter_test.sv =====
`timescale 1ns / 1ps
module rgb_to_hsl_converter_test;

  typedef struct packed {
    logic [rth_pkg::SumW-1:0] lightness_sum;
    logic [rth_pkg::SatW-1:0] saturation;
    logic [rth_pkg::HueW-1:0] hue;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t pending[$];
    int errors;
    int checked;

    function hsl_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      hsl_t res;
      int mx, mn, d, den, n;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      res = '0;
      res.lightness_sum = rth_pkg::SumW'(mx + mn);
      if (d > 0) begin
        den = (mx + mn <= 255) ? mx + mn : 510 - mx - mn;
        res.saturation = rth_pkg::SatW'((longint'(rth_pkg::SatScale) * d) / den);
        if (mx == r) begin
          n = int'(g) - int'(b);
          if (g < b) n += 6 * d;
        end else if (mx == g) begin
          n = int'(b) - int'(r) + 2 * d;
        end else begin
          n = int'(r) - int'(g) + 4 * d;
        end
        if (n < 0) n = 0;
        res.hue = rth_pkg::HueW'((rth_pkg::HueScale * n) / d);
      end
      return res;
    endfunction

    function void note_pixel(logic [23:0] px);
      pending.push_back(convert(px[7:0], px[15:8], px[23:16]));
    endfunction

    function void check_result(logic [39:0] data);
      hsl_t got, want;
      got = hsl_t'(data);
      checked++;
      if (pending.size() == 0) begin
        $error("result with no pixel pending: %h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue expected %0d actual %0d", want.hue, got.hue);
        errors++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation expected %0d actual %0d", want.saturation, got.saturation);
        errors++;
      end
      if (got.lightness_sum !== want.lightness_sum) begin
        $error("lightness_sum expected %0d actual %0d", want.lightness_sum,
               got.lightness_sum);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [39:0] m_axis_tdata;

  hsl_scoreboard sb = new();
  bit quiet_tail = 0;
  bit hold_sink = 0;
  int sent = 0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  rgb_to_hsl_converter DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("FAIL rgb_to_hsl_converter");
        $finish;
      end
    end
  end

  // sink side: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (60) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        m_axis_tready <= 1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int n;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [7:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] r, g, b;
    int wait_cycles;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: greys, primaries, ties, extremes
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(255, 255, 254);
    send_pixel(200, 10, 200);
    send_pixel(255, 0, 1);
    send_pixel(254, 255, 255);
    send_pixel(1, 0, 0);
    send_pixel(255, 254, 254);
    send_pixel(127, 128, 128);
    send_pixel(128, 127, 127);
    send_pixel(170, 85, 85);
    send_pixel(10, 20, 30);
    send_pixel(30, 20, 10);
    send_pixel(85, 170, 255);
    hold_sink = 1;
    for (int i = 0; i < 1430; i++) begin
      if (i == 1300) quiet_tail = 1;
      r = pick_comp();
      g = pick_comp();
      b = pick_comp();
      case ($urandom_range(0, 9))
        0: begin g = r; b = r; end
        1: g = r;
        2: b = g;
        3: b = r;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    s_axis_tvalid <= 0;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    $display("converted %0d pixels, checked %0d results", sent, sb.checked);
    $display("greys, tied maxima, extremes and random pixels under stalls");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS rgb_to_hsl_converter");
    else
      $display("FAIL rgb_to_hsl_converter");
    $finish;
  end
endmodule
